// ===== src/sc1kt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sc1kt_pkg: set-1 scan byte translator package
// Byte codes, key codes, lookup functions and shared types.
// ----------------------------------------------------------------------------
package sc1kt_pkg;

    localparam logic [7:0] ESCAPE_PREFIX = 8'hE0;
    localparam logic [7:0] ALT_MAKE      = 8'h38;
    localparam logic [7:0] ALT_BREAK     = 8'hB8;
    localparam logic [7:0] CODE_NONE     = 8'd0;
    localparam logic [7:0] CODE_LEFTALT  = 8'd56;
    localparam logic [7:0] CODE_RIGHTALT = 8'd100;

    typedef struct packed {
        logic escape_pending;
        logic left_alt_down;
        logic right_alt_down;
    } t_flags;

    typedef struct packed {
        logic       valid;
        logic [7:0] key_code;
        logic       pressed;
    } t_result;

    function automatic logic [7:0] normal_lookup(input logic [6:0] code);
        logic [7:0] key;
        key = CODE_NONE;
        if (code inside {[7'h01:7'h36], [7'h39:7'h44], [7'h56:7'h58]}) begin
            key = {1'b0, code};
        end
        return key;
    endfunction

    function automatic logic [7:0] escaped_lookup(input logic [6:0] code);
        logic [7:0] key;
        case (code)
            7'h1C: key = 8'd96;
            7'h1D: key = 8'd97;
            7'h35: key = 8'd98;
            7'h37: key = 8'd99;
            7'h38: key = 8'd100;
            7'h47: key = 8'd102;
            7'h48: key = 8'd103;
            7'h49: key = 8'd104;
            7'h4B: key = 8'd105;
            7'h4D: key = 8'd106;
            7'h4F: key = 8'd107;
            7'h50: key = 8'd108;
            7'h51: key = 8'd109;
            7'h52: key = 8'd110;
            7'h53: key = 8'd111;
            7'h5B: key = 8'd125;
            7'h5C: key = 8'd126;
            7'h5D: key = 8'd139;
            default: key = CODE_NONE;
        endcase
        return key;
    endfunction

endpackage
`default_nettype wire

// ===== src/sc1kt_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sc1kt_byte_if: scan byte channel
// Valid/ready channel carrying one raw keyboard byte per request.
// ----------------------------------------------------------------------------
interface sc1kt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface
`default_nettype wire

// ===== src/sc1kt_key_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sc1kt_key_if: key event channel
// Valid/ready channel carrying one key code and pressed flag per request.
// ----------------------------------------------------------------------------
interface sc1kt_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;
    logic       pressed;

    modport source (output valid, output key_code, output pressed, input ready);
    modport sink   (input valid, input key_code, input pressed, output ready);
endinterface
`default_nettype wire

// ===== src/scancode_set1_key_translator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scancode_set1_key_translator: set-1 scan byte to input key code
// Turns raw keyboard bytes into key code / pressed events, with escape
// prefix handling and the inverted Alt rule of this keyboard.
// ----------------------------------------------------------------------------
// One scan byte is taken per clock cycle, sustained, as long as the key
// event channel keeps up. A byte passes the input register, is decoded
// combinationally against the escape and Alt flags, and its event, if any,
// is then held in the result register, which drives the output. The prefix byte
// and bytes that map to no key give no event. The input register lets a
// new byte be taken while an event still waits downstream.
module scancode_set1_key_translator
    import sc1kt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sc1kt_byte_if.sink   i_byte,
    sc1kt_key_if.source  o_key
);
    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_free;
    logic       step;
    t_result    result;

    assign step = in_valid && out_free;

    sc1kt_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_byte.valid),
        .i_byte    (i_byte.scan_byte),
        .i_advance (out_free),
        .o_ready   (i_byte.ready),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    sc1kt_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (in_byte),
        .o_result (result)
    );

    sc1kt_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (result),
        .i_ready    (o_key.ready),
        .o_free     (out_free),
        .o_valid    (o_key.valid),
        .o_key_code (o_key.key_code),
        .o_pressed  (o_key.pressed)
    );
endmodule
`default_nettype wire

// ===== src/sc1kt_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sc1kt_in_stage: input register
// Holds one accepted scan byte until the decode step can consume it.
// ----------------------------------------------------------------------------
module sc1kt_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_advance,
    output logic            o_ready,
    output logic            o_valid,
    output logic [7:0]      o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end
endmodule
`default_nettype wire

// ===== src/sc1kt_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sc1kt_decode: scan byte decoder
// Escape and Alt flag registers plus the table lookup for one byte.
// ----------------------------------------------------------------------------
module sc1kt_decode
    import sc1kt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output t_result         o_result
);
    t_flags r_flags;
    t_flags n_flags;
    logic [7:0] key;
    logic       down;

    always_comb begin
        n_flags = r_flags;
        key     = CODE_NONE;
        down    = 1'b1;
        if (i_byte == ESCAPE_PREFIX) begin
            n_flags.escape_pending = 1'b1;
        end else begin
            n_flags.escape_pending = 1'b0;
            if (!r_flags.escape_pending && i_byte == ALT_MAKE) begin
                if (r_flags.right_alt_down) begin
                    n_flags.right_alt_down = 1'b0;
                    key  = CODE_RIGHTALT;
                    down = 1'b0;
                end else begin
                    n_flags.left_alt_down = 1'b1;
                    key = CODE_LEFTALT;
                end
            end else if (!r_flags.escape_pending && i_byte == ALT_BREAK) begin
                if (r_flags.left_alt_down) begin
                    n_flags.left_alt_down = 1'b0;
                    key  = CODE_LEFTALT;
                    down = 1'b0;
                end else begin
                    n_flags.right_alt_down = 1'b1;
                    key = CODE_RIGHTALT;
                end
            end else begin
                down = !i_byte[7];
                if (r_flags.escape_pending) begin
                    key = escaped_lookup(i_byte[6:0]);
                end else begin
                    key = normal_lookup(i_byte[6:0]);
                end
            end
        end
    end

    assign o_result.valid    = (key != CODE_NONE);
    assign o_result.key_code = key;
    assign o_result.pressed  = down;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_step) begin
            r_flags <= n_flags;
        end
    end
endmodule
`default_nettype wire

// ===== src/sc1kt_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sc1kt_out_stage: result register
// Holds one key event until the downstream side takes it.
// ----------------------------------------------------------------------------
module sc1kt_out_stage
    import sc1kt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_result    i_result,
    input  wire logic       i_ready,
    output logic            o_free,
    output logic            o_valid,
    output logic [7:0]      o_key_code,
    output logic            o_pressed
);
    logic       r_valid;
    logic [7:0] r_key_code;
    logic       r_pressed;

    assign o_free     = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_key_code = r_key_code;
    assign o_pressed  = r_pressed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_result.valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_key_code <= i_result.key_code;
            r_pressed  <= i_result.pressed;
        end
    end
endmodule
`default_nettype wire
